/* design/sbt_pkg.sv */
// Package for the SQL byte tokenizer: item structs, event/kind codes,
// scan phase enum and byte classes. No dependencies.
package sbt_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int START_W      = 16;
	localparam int RES_MAX      = 3;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	typedef enum logic [2:0] {
		EV_CHAR     = 3'd0,
		EV_COMPLETE = 3'd1,
		EV_END      = 3'd2,
		EV_BADCHAR  = 3'd3,
		EV_UNTERM   = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		TK_WORD   = 4'd0,
		TK_NUMBER = 4'd1,
		TK_STRING = 4'd2,
		TK_STAR   = 4'd3,
		TK_COMMA  = 4'd4,
		TK_LPAREN = 4'd5,
		TK_RPAREN = 4'd6,
		TK_SEMI   = 4'd7,
		TK_END    = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WORD  = 2'd1,
		PH_STR   = 2'd2,
		PH_QUOTE = 2'd3
	} phase_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] text_byte;
	} sbt_in_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [3:0]         token_kind;
		logic [7:0]         char_value;
		logic [START_W-1:0] token_start;
		logic               last_of_run;
	} sbt_out_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
			|| (b == CH_UNDER);
	endfunction

	function automatic sbt_out_t make_res(input event_t ev, input kind_t kind,
		input logic [7:0] ch, input logic [START_W-1:0] start);
		sbt_out_t r;
		r.event_res   = ev;
		r.token_kind  = kind;
		r.char_value  = ch;
		r.token_start = start;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

/* design/sql_byte_tokenizer_core.sv */
// Streaming SQL tokenizer top level: input stage, lexer state, result buffer.
// Depends on sbt_pkg.
//
//  channel | signals                     | payload
//  --------+-----------------------------+------------------------------
//  in      | in_valid / in_ready         | in_data  (sbt_in_t)
//  out     | out_valid / out_ready       | out_data (sbt_out_t)
//
// An item is registered, then lexed into up to three results held in a small buffer;
// results leave at one per cycle while out_ready is high. Items giving zero or one
// result flow at one per cycle under that condition; an item giving more occupies the
// output until its last result leaves. Results come from the buffer register, after the input stage.
// Reset clears the input stage, lexer state and buffer count.
// out_ready low holds the buffer; in_ready drops once the input stage is full and the
// buffer cannot take its results.
module sql_byte_tokenizer_core #(
	parameter int POSITION_BITS = sbt_pkg::POS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbt_pkg::sbt_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sbt_pkg::sbt_out_t out_data
);
	import sbt_pkg::*;

	logic                     valid_s1;
	sbt_in_t                  item_s1;

	phase_t                   phase_q, phase_c;
	kind_t                    open_kind_q, open_kind_c;
	logic [START_W-1:0]       open_start_q, open_start_c;
	logic [POSITION_BITS-1:0] pos_q, pos_c;
	logic                     stop_q, stop_c;

	sbt_out_t                 res_q [RES_MAX];
	sbt_out_t                 res_c [RES_MAX];
	logic [1:0]               res_cnt_q, res_cnt_c;
	logic [1:0]               res_rd_q;

	logic                     drain_last, proc;
	logic [START_W-1:0]       p16;
	logic [7:0]               b;
	logic                     do_between;
	kind_t                    single_kind;
	logic                     is_single;

	assign out_valid  = (res_cnt_q != 2'd0);
	assign out_data   = res_q[res_rd_q];
	assign drain_last = out_valid && out_ready && ((res_rd_q + 2'd1) == res_cnt_q);
	assign proc       = valid_s1 && ((res_cnt_q == 2'd0) || drain_last);
	assign in_ready   = !valid_s1 || proc;

	assign p16 = START_W'(pos_q);
	assign b   = item_s1.text_byte;

	always_comb begin
		is_single   = 1'b1;
		single_kind = TK_STAR;
		case (b)
			CH_STAR:   single_kind = TK_STAR;
			CH_COMMA:  single_kind = TK_COMMA;
			CH_LPAREN: single_kind = TK_LPAREN;
			CH_RPAREN: single_kind = TK_RPAREN;
			CH_SEMI:   single_kind = TK_SEMI;
			default:   is_single = 1'b0;
		endcase
	end

	// Lexer step: results are appended in order, completion of an open token first.
	always_comb begin
		phase_c      = phase_q;
		open_kind_c  = open_kind_q;
		open_start_c = open_start_q;
		pos_c        = pos_q;
		stop_c       = stop_q;
		res_cnt_c    = 2'd0;
		do_between   = 1'b0;
		for (int i = 0; i < RES_MAX; i++) begin
			res_c[i] = make_res(EV_CHAR, TK_WORD, 8'h00, '0);
		end

		if (item_s1.mode) begin
			if (!stop_q) begin
				if (phase_q == PH_STR) begin
					res_c[res_cnt_c] = make_res(EV_UNTERM, TK_WORD, 8'h00, open_start_q);
					res_cnt_c = res_cnt_c + 2'd1;
				end else begin
					if (phase_q == PH_WORD || phase_q == PH_QUOTE) begin
						res_c[res_cnt_c] = make_res(EV_COMPLETE, open_kind_q, 8'h00,
							open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
					end
					res_c[res_cnt_c] = make_res(EV_END, TK_END, 8'h00, p16);
					res_cnt_c = res_cnt_c + 2'd1;
				end
			end
			phase_c      = PH_IDLE;
			open_kind_c  = TK_WORD;
			open_start_c = '0;
			pos_c        = '0;
			stop_c       = 1'b0;
		end else if (!stop_q) begin
			case (phase_q)
				PH_WORD: begin
					if (is_word(b)) begin
						res_c[res_cnt_c] = make_res(EV_CHAR, open_kind_q, b, open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
					end else begin
						res_c[res_cnt_c] = make_res(EV_COMPLETE, open_kind_q, 8'h00,
							open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
						do_between = 1'b1;
					end
				end
				PH_STR: begin
					if (b == CH_QUOTE) begin
						phase_c = PH_QUOTE;
					end else begin
						res_c[res_cnt_c] = make_res(EV_CHAR, TK_STRING, b, open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
					end
				end
				PH_QUOTE: begin
					// doubled quote is one literal quote
					if (b == CH_QUOTE) begin
						res_c[res_cnt_c] = make_res(EV_CHAR, TK_STRING, b, open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
						phase_c = PH_STR;
					end else begin
						res_c[res_cnt_c] = make_res(EV_COMPLETE, TK_STRING, 8'h00,
							open_start_q);
						res_cnt_c = res_cnt_c + 2'd1;
						do_between = 1'b1;
					end
				end
				default: do_between = 1'b1;
			endcase

			if (do_between) begin
				phase_c = PH_IDLE;
				if (is_space(b)) begin
					phase_c = PH_IDLE;
				end else if (is_word(b)) begin
					open_kind_c  = is_digit(b) ? TK_NUMBER : TK_WORD;
					open_start_c = p16;
					phase_c      = PH_WORD;
					res_c[res_cnt_c] = make_res(EV_CHAR, open_kind_c, b, p16);
					res_cnt_c = res_cnt_c + 2'd1;
				end else if (b == CH_QUOTE) begin
					open_kind_c  = TK_STRING;
					open_start_c = p16;
					phase_c      = PH_STR;
				end else if (is_single) begin
					res_c[res_cnt_c] = make_res(EV_CHAR, single_kind, b, p16);
					res_cnt_c = res_cnt_c + 2'd1;
					res_c[res_cnt_c] = make_res(EV_COMPLETE, single_kind, 8'h00, p16);
					res_cnt_c = res_cnt_c + 2'd1;
				end else begin
					res_c[res_cnt_c] = make_res(EV_BADCHAR, TK_WORD, b, p16);
					res_cnt_c = res_cnt_c + 2'd1;
					stop_c = 1'b1;
				end
			end

			if (pos_q != {POSITION_BITS{1'b1}}) begin
				pos_c = pos_q + {{(POSITION_BITS-1){1'b0}}, 1'b1};
			end
		end

		if (res_cnt_c != 2'd0) begin
			res_c[res_cnt_c - 2'd1].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			open_kind_q  <= TK_WORD;
			open_start_q <= '0;
			pos_q        <= '0;
			stop_q       <= 1'b0;
			res_cnt_q    <= 2'd0;
			res_rd_q     <= 2'd0;
		end else if (proc) begin
			phase_q      <= phase_c;
			open_kind_q  <= open_kind_c;
			open_start_q <= open_start_c;
			pos_q        <= pos_c;
			stop_q       <= stop_c;
			res_cnt_q    <= res_cnt_c;
			res_rd_q     <= 2'd0;
		end else if (out_valid && out_ready) begin
			if (drain_last) begin
				res_cnt_q <= 2'd0;
				res_rd_q  <= 2'd0;
			end else begin
				res_rd_q <= res_rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < RES_MAX; i++) begin
				res_q[i] <= res_c[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_rd_q < res_cnt_q))
		else $error("result read pointer past buffer count");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_of_run == ((res_rd_q + 2'd1) == res_cnt_q)))
		else $error("last_of_run does not mark the final buffered result");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !item_s1.mode && stop_q) |=> (res_cnt_q == 2'd0))
		else $error("text item produced results while stopped on error");

	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !item_s1.mode) |=> (pos_q >= $past(pos_q)))
		else $error("byte position moved backward on a text item");
`endif

endmodule
